// File: rtl/core/assert_macros.svh
// Assertion macros for the checker file of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is held.
`define CFR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("frame receiver check failed");

// Clocked assertion that also holds while reset is held.
`define CFR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("frame receiver check failed");

`endif

// File: rtl/core/cfr_pkg.sv
// Types and constants shared by the CRC-checked frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

  localparam int unsigned WIN_DEPTH = 8;
  localparam int unsigned CRC_SPAN  = 7;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned CRC_BITS  = CRC_SPAN * BYTE_W;
  localparam int unsigned CNT_W     = $clog2(CRC_BITS);
  localparam int unsigned IDX_W     = $clog2(WIN_DEPTH);
  localparam int unsigned FILL_W    = $clog2(WIN_DEPTH + 1);

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  typedef logic [WIN_DEPTH-1:0][BYTE_W-1:0] win_t;

  typedef struct packed {
    logic push;
    logic slide;
    logic clear;
  } win_ctrl_t;

  typedef struct packed {
    logic init;
    logic step;
  } crc_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CRC,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// File: rtl/core/cfr_crc_unit.sv
// Bit-serial CRC-16/MODBUS engine, one data bit per step.
`timescale 1ns / 1ps
`default_nettype none

module cfr_crc_unit
  import cfr_pkg::*;
(
  input  wire              clk_i,
  input  crc_ctrl_t        ctrl_i,
  input  wire              bit_i,
  output logic [CRC_W-1:0] crc_o
);

  logic [CRC_W-1:0] crc_q, crc_d;
  logic             fb;

  // Load the initial value, or shift one reflected bit through the polynomial
  always_comb begin
    fb    = crc_q[0] ^ bit_i;
    crc_d = crc_q;
    if (ctrl_i.init) begin
      crc_d = CRC_INIT;
    end else if (ctrl_i.step) begin
      crc_d = {1'b0, crc_q[CRC_W-1:1]} ^ (fb ? CRC_POLY : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
  end

  assign crc_o = crc_q;

endmodule

`default_nettype wire

// File: rtl/core/cfr_window.sv
// Eight-byte receive window with fill count, append and slide.
`timescale 1ns / 1ps
`default_nettype none

module cfr_window
  import cfr_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  win_ctrl_t         ctrl_i,
  input  wire  [BYTE_W-1:0] byte_i,
  output win_t              win_o,
  output logic              full_o
);

  logic [FILL_W-1:0] fill_q, fill_d;
  win_t              win_q;

  // Track the number of stored bytes
  always_comb begin
    fill_d = fill_q;
    if (ctrl_i.clear) begin
      fill_d = '0;
    end else if (ctrl_i.push) begin
      fill_d = fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Append at the fill position, or drop the oldest byte and shift in
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      win_q[fill_q[IDX_W-1:0]] <= byte_i;
    end else if (ctrl_i.slide) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WIN_DEPTH-1] <= byte_i;
    end
  end

  assign win_o  = win_q;
  assign full_o = (fill_q == FILL_W'(WIN_DEPTH));

endmodule

`default_nettype wire

// File: rtl/core/crc_checked_frame_receiver_unit.sv
// Top level of the CRC-checked frame receiver: sequencer and result register.
//
//   channel  direction  handshake               payload
//   rx in    input      in_valid_i / in_stall_o  rx_byte_i
//   frame    output     out_valid_o / out_stall_i frame_command_o, payload_*_o
//
// A byte that lands in a window with room is appended and the input stays open.
// The ninth byte of a frame starts a bit-serial CRC over window bytes 0..6, then
// a decision state; the input stays stalled until the sequencer is back in idle.
// The CRC engine is stepped one bit per cycle.
// Reset clears the fill count and the sequencer; window bytes are undefined until written.
// A waiting result holds in the output register; a new match waits for it to be taken.
`timescale 1ns / 1ps
`default_nettype none

module crc_checked_frame_receiver_unit
  import cfr_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire  [BYTE_W-1:0] rx_byte_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [BYTE_W-1:0] frame_command_o,
  output logic [BYTE_W-1:0] payload_one_o,
  output logic [BYTE_W-1:0] payload_two_o,
  output logic [BYTE_W-1:0] payload_three_o,
  output logic [BYTE_W-1:0] payload_four_o,
  output logic [BYTE_W-1:0] payload_five_o,
  output logic [BYTE_W-1:0] payload_six_o
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [BYTE_W-1:0]  hold_q;
  logic               hold_en;
  logic               out_valid_q, out_valid_d;
  logic               out_load;
  logic               crc_match;
  logic               crc_bit;
  logic [CRC_W-1:0]   crc;
  logic [BYTE_W-1:0]  win_byte;
  logic [BYTE_W-1:0]  win_wr_byte;
  logic               win_full;
  win_t               win;
  win_ctrl_t          win_ctrl;
  crc_ctrl_t          crc_ctrl;

  // Pick the window bit that the CRC engine consumes this cycle
  assign win_byte  = win[cnt_q[CNT_W-1:3]];
  assign crc_bit   = win_byte[cnt_q[2:0]];
  assign crc_match = (crc == {hold_q, win[WIN_DEPTH-1]});

  // Slide shifts in the held ninth byte; append takes the incoming byte
  assign win_wr_byte = win_ctrl.slide ? hold_q : rx_byte_i;

  // Next state and control; the input is open only in idle
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    hold_en     = 1'b0;
    out_load    = 1'b0;
    win_ctrl    = '0;
    crc_ctrl    = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (!win_full) begin
            win_ctrl.push = 1'b1;
          end else begin
            hold_en       = 1'b1;
            crc_ctrl.init = 1'b1;
            cnt_d         = '0;
            state_d       = ST_CRC;
          end
        end
      end
      ST_CRC: begin
        crc_ctrl.step = 1'b1;
        cnt_d         = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(CRC_BITS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (crc_match) begin
          if (!(out_valid_q && out_stall_i)) begin
            out_load       = 1'b1;
            out_valid_d    = 1'b1;
            win_ctrl.clear = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          win_ctrl.slide = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the ninth byte and the emitted frame
  always_ff @(posedge clk_i) begin
    if (hold_en) begin
      hold_q <= rx_byte_i;
    end
    if (out_load) begin
      frame_command_o <= win[0];
      payload_one_o   <= win[1];
      payload_two_o   <= win[2];
      payload_three_o <= win[3];
      payload_four_o  <= win[4];
      payload_five_o  <= win[5];
      payload_six_o   <= win[6];
    end
  end

  assign out_valid_o = out_valid_q;

  cfr_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .byte_i (win_wr_byte),
    .win_o  (win),
    .full_o (win_full)
  );

  cfr_crc_unit u_crc (
    .clk_i  (clk_i),
    .ctrl_i (crc_ctrl),
    .bit_i  (crc_bit),
    .crc_o  (crc)
  );

endmodule

`default_nettype wire

// File: rtl/core/cfr_checker.sv
// Port-level checks of the frame receiver and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cfr_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_stall_o,
  input wire [7:0] rx_byte_i,
  input wire       out_valid_o,
  input wire       out_stall_i,
  input wire [7:0] frame_command_o,
  input wire [7:0] payload_one_o,
  input wire [7:0] payload_two_o,
  input wire [7:0] payload_three_o,
  input wire [7:0] payload_four_o,
  input wire [7:0] payload_five_o,
  input wire [7:0] payload_six_o
);

  logic [55:0] frame_bits;

  // Gather the whole result payload
  assign frame_bits = {payload_six_o, payload_five_o, payload_four_o, payload_three_o,
                       payload_two_o, payload_one_o, frame_command_o};

  // Stalled result holds valid and payload
  `CFR_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_bits))

  // Stalled input transaction holds valid and byte
  `CFR_ASSERT(a_in_hold, in_valid_i && in_stall_o |=> in_valid_i && $stable(rx_byte_i))

  // A result appears only out of a busy cycle
  `CFR_ASSERT(a_out_from_busy, $rose(out_valid_o) |-> $past(in_stall_o))

  // Busy starts only after an accepted transaction
  `CFR_ASSERT(a_busy_after_acc, $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))

  // No result is shown while reset is held
  `CFR_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o || rst_ni)

endmodule

bind crc_checked_frame_receiver_unit cfr_checker u_cfr_checker (.*);

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the CRC-checked frame receiver.
`timescale 1ns / 1ps

module tb_top;
  import cfr_pkg::*;

  localparam int unsigned FRAME_BYTES   = CRC_SPAN + 2;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 800;
  localparam int unsigned TAIL_ITEMS    = 100;

  // Command byte followed by six payload bytes; element 0 is the command.
  typedef logic [CRC_SPAN-1:0][BYTE_W-1:0] frame_t;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              in_valid_i = 1'b0;
  logic [BYTE_W-1:0] rx_byte_i  = '0;
  logic              out_stall_i = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [BYTE_W-1:0] frame_command_o;
  logic [BYTE_W-1:0] payload_one_o;
  logic [BYTE_W-1:0] payload_two_o;
  logic [BYTE_W-1:0] payload_three_o;
  logic [BYTE_W-1:0] payload_four_o;
  logic [BYTE_W-1:0] payload_five_o;
  logic [BYTE_W-1:0] payload_six_o;

  // Predictor state: the receive window and its fill level.
  logic [BYTE_W-1:0] rx_window [WIN_DEPTH];
  int unsigned       fill_level = 0;
  frame_t            pending_frames [$];

  int unsigned error_count = 0;
  int unsigned bytes_sent  = 0;
  bit          idling_on   = 1'b1;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left   = 0;

  string field_name [CRC_SPAN] = '{"frame_command", "payload_one", "payload_two",
                                   "payload_three", "payload_four", "payload_five",
                                   "payload_six"};

  crc_checked_frame_receiver_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_command_o (frame_command_o),
    .payload_one_o   (payload_one_o),
    .payload_two_o   (payload_two_o),
    .payload_three_o (payload_three_o),
    .payload_four_o  (payload_four_o),
    .payload_five_o  (payload_five_o),
    .payload_six_o   (payload_six_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // CRC-16/MODBUS over the seven frame body bytes, one bit at a time
  function automatic logic [CRC_W-1:0] crc16_modbus(input frame_t body);
    logic [CRC_W-1:0] crc;
    int               i;
    int               b;
    crc = CRC_INIT;
    for (i = 0; i < CRC_SPAN; i++) begin
      crc = crc ^ {8'h00, body[i]};
      for (b = 0; b < BYTE_W; b++) begin
        if (crc[0]) begin
          crc = (crc >> 1) ^ CRC_POLY;
        end else begin
          crc = crc >> 1;
        end
      end
    end
    return crc;
  endfunction

  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] want);
    $display("[%0t] MISMATCH %s: got %02h, expected %02h", $realtime, what, got, want);
    error_count++;
  endtask

  // Advance the predicted window by one accepted byte; queue a frame on a CRC match
  task automatic absorb_byte(input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] sent_crc;
    frame_t           body;
    int               i;
    if (fill_level < WIN_DEPTH) begin
      rx_window[fill_level] = b;
      fill_level++;
    end else begin
      for (i = 0; i < CRC_SPAN; i++) body[i] = rx_window[i];
      sent_crc = {b, rx_window[WIN_DEPTH-1]};
      if (crc16_modbus(body) == sent_crc) begin
        pending_frames.push_back(body);
        fill_level = 0;
      end else begin
        // drop the oldest byte and slide the window
        for (i = 0; i < WIN_DEPTH - 1; i++) rx_window[i] = rx_window[i+1];
        rx_window[WIN_DEPTH-1] = b;
      end
    end
  endtask

  // Offer one byte, with an optional random gap in front, and wait for its transaction
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    absorb_byte(b);
    bytes_sent++;
  endtask

  // Send a body with its CRC, optionally with one bit flipped somewhere in the frame
  task automatic send_frame(input frame_t body, input bit corrupt);
    logic [FRAME_BYTES-1:0][BYTE_W-1:0] wire_bytes;
    logic [CRC_W-1:0]                   crc;
    int unsigned                        pos;
    int unsigned                        bit_pos;
    int                                 k;
    crc = crc16_modbus(body);
    wire_bytes[CRC_SPAN-1:0] = body;
    wire_bytes[CRC_SPAN]     = crc[7:0];
    wire_bytes[CRC_SPAN+1]   = crc[15:8];
    if (corrupt) begin
      pos     = $urandom_range(0, FRAME_BYTES - 1);
      bit_pos = $urandom_range(0, BYTE_W - 1);
      wire_bytes[pos][bit_pos] = ~wire_bytes[pos][bit_pos];
    end
    for (k = 0; k < FRAME_BYTES; k++) send_byte(wire_bytes[k]);
  endtask

  function automatic frame_t random_body(input logic [BYTE_W-1:0] cmd);
    frame_t body;
    int     i;
    body[0] = cmd;
    for (i = 1; i < CRC_SPAN; i++) body[i] = BYTE_W'($urandom_range(0, 255));
    return body;
  endfunction

  // Compare each frame transaction with the oldest predicted frame
  always @(posedge clk_i) begin : frame_check
    frame_t got;
    frame_t want;
    int     i;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {payload_six_o, payload_five_o, payload_four_o, payload_three_o,
             payload_two_o, payload_one_o, frame_command_o};
      if (pending_frames.size() == 0) begin
        report_mismatch("unexpected frame, command", got[0], 8'h00);
      end else begin
        want = pending_frames.pop_front();
        for (i = 0; i < CRC_SPAN; i++) begin
          if (got[i] !== want[i]) report_mismatch(field_name[i], got[i], want[i]);
        end
      end
    end
  end

  // Hold off the frame output in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 14);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // End the run when no transaction happens on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic apply_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  // Frames of all-zero and all-one bytes
  task automatic test_extreme_frames();
    send_frame('0, 1'b0);
    send_frame('1, 1'b0);
  endtask

  // A stray byte in front forces a CRC mismatch, then the window resynchronises
  task automatic test_resync_after_stray_byte();
    send_byte(8'h5A);
    send_frame(random_body(8'd3), 1'b0);
  endtask

  // Mostly well-formed frames, with corrupted frames and line noise mixed in
  task automatic test_random_traffic(input int unsigned target);
    int unsigned r;
    int unsigned noise;
    logic [BYTE_W-1:0] cmd;
    target += bytes_sent;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        cmd = BYTE_W'($urandom_range(1, 4));
      end else begin
        cmd = BYTE_W'($urandom_range(0, 255));
      end
      if (r < 70) begin
        send_frame(random_body(cmd), 1'b0);
      end else if (r < 85) begin
        send_frame(random_body(cmd), 1'b1);
      end else begin
        noise = $urandom_range(1, 3);
        repeat (noise) send_byte(BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // Back-to-back clean frames with no idling on either side
  task automatic test_quiet_tail(input int unsigned target);
    idling_on = 1'b0;
    target += bytes_sent;
    while (bytes_sent < target) send_frame(random_body(BYTE_W'($urandom_range(1, 4))), 1'b0);
  endtask

  initial begin
    apply_reset();
    test_extreme_frames();
    test_resync_after_stray_byte();
    test_random_traffic(RANDOM_ITEMS);
    test_quiet_tail(TAIL_ITEMS);
    in_valid_i <= 1'b0;
    // drain outstanding frames, then allow for a late spurious one
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_frames.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/cfr_pkg.sv
rtl/core/cfr_crc_unit.sv
rtl/core/cfr_window.sv
rtl/core/crc_checked_frame_receiver_unit.sv
rtl/core/cfr_checker.sv
dv/tb_top.sv
